// File: sv/rm_exact_schedulability_test_macros.svh
// Assertion macros shared by the schedulability test RTL.
`ifndef RM_EXACT_SCHEDULABILITY_TEST_MACROS_SVH
`define RM_EXACT_SCHEDULABILITY_TEST_MACROS_SVH

`ifndef SYNTHESIS
`define RMEST_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rmest check failed");
`define RMEST_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("rmest invariant failed");
`else
`define RMEST_ASSERT_IMPL(label, ante, cons)
`define RMEST_ASSERT_ALWAYS(label, cond)
`endif

`endif

// File: sv/rmest_pkg.sv
// Types, constants and codes of the rate-monotonic schedulability test.
package rmest_pkg;

   localparam int MAX_TASKS_DEF = 32;
   localparam int TIME_BITS_DEF = 16;
   localparam int TIME_MAX      = 32;

   localparam int FIELD_W  = 16;
   localparam int REQ_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;
   localparam int RSP_W    = 8;

   localparam logic [STATUS_W-1:0] STATUS_FAIL     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PT_RD,
      ST_PT_CAP,
      ST_J_RD,
      ST_J_CAP,
      ST_DIV,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: sv/rm_exact_schedulability_test.sv
// Task words fill the store; a last word starts the test or flags overflow.
// Each demand term reads the store, runs the shared divider, then multiplies
// and accumulates. A task reads the store before its first scheduling point,
// and the verdict word appears the cycle after the deciding accumulate.
// Throughput: one task word per cycle while loading and the result register
// is free or being drained; no words during a test.
// Reset is synchronous and active high; the task store is not cleared.
`include "rm_exact_schedulability_test_macros.svh"

module rm_exact_schedulability_test #(
   parameter int MAX_TASKS = rmest_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS = rmest_pkg::TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: period [15:0], wcet [31:16]. req_tlast: last task of the set.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [rmest_pkg::REQ_W-1:0]  req_tdata,
   input  logic                         req_tlast,
   // rsp_tdata: status [1:0], task_count [7:2].
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [rmest_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int T      = TIME_BITS;
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int PROD_W = 2 * T;
   localparam int DEM_W  = 2 * T + 1;

   // Incoming fields, trimmed to the time width. A zero period counts as one.
   logic [rmest_pkg::TIME_MAX-1:0] period_ext;
   logic [rmest_pkg::TIME_MAX-1:0] wcet_ext;
   logic [T-1:0]                   period_t;
   logic [T-1:0]                   wcet_t;

   assign period_ext = rmest_pkg::TIME_MAX'(req_tdata[rmest_pkg::FIELD_W-1:0]);
   assign wcet_ext   = rmest_pkg::TIME_MAX'(req_tdata[2*rmest_pkg::FIELD_W-1:rmest_pkg::FIELD_W]);
   assign period_t   = (period_ext[T-1:0] == '0) ? T'(1) : period_ext[T-1:0];
   assign wcet_t     = wcet_ext[T-1:0];

   // Sequencer and set state.
   rmest_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [T-1:0]       tmax_ff, tmax_in;
   logic               over_ff, over_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [T-1:0]       pi_ff, pi_in;
   logic [T-1:0]       s_ff, s_in;
   logic [T-1:0]       c_ff, c_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DEM_W-1:0]   demand_ff, demand_in;

   // Result register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rmest_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [rmest_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // Store and divider connections.
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [2*T-1:0]       ram_rd_data;
   logic                 div_start;
   logic [T-1:0]         div_jobs;
   rmest_pkg::div_status_type div_st;

   // Helpers for the finishing step.
   logic                           accept;
   logic                           finish;
   logic [rmest_pkg::STATUS_W-1:0] fin_status;
   logic [31:0]                    count_ext;
   logic [DEM_W-1:0]               demand_sum;
   logic [T:0]                     s_next;

   assign accept    = req_tvalid && req_tready;
   assign count_ext = 32'(count_ff);
   assign demand_sum = demand_ff + DEM_W'(prod_ff);
   assign s_next     = {1'b0, s_ff} + {1'b0, pi_ff};

   // Tasks are loaded while the result register is free or being drained,
   // so a closing word always finds room for its result.
   assign req_tready = (state_ff == rmest_pkg::ST_LOAD) && (!rsp_valid_ff || rsp_tready);

   rmest_ram #(
      .WIDTH (2 * T),
      .DEPTH (MAX_TASKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({wcet_t, period_t}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rmest_div #(
      .W (T)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (s_ff),
      .divisor  (ram_rd_data[T-1:0]),
      .jobs     (div_jobs),
      .status   (div_st)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      tmax_in       = tmax_ff;
      over_in       = over_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pi_in         = pi_ff;
      s_in          = s_ff;
      c_in          = c_ff;
      prod_in       = prod_ff;
      demand_in     = demand_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_rd_addr   = i_ff[IDX_W-1:0];
      div_start     = 1'b0;
      finish        = 1'b0;
      fin_status    = rmest_pkg::STATUS_FAIL;

      case (state_ff)
         rmest_pkg::ST_LOAD: begin
            if (accept) begin
               if (count_ff < CNT_W'(MAX_TASKS)) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  if (period_t > tmax_ff) begin
                     tmax_in = period_t;
                  end
               end else begin
                  over_in = 1'b1;
               end
               if (req_tlast) begin
                  if (over_in) begin
                     finish     = 1'b1;
                     fin_status = rmest_pkg::STATUS_OVERFLOW;
                  end else begin
                     i_in     = '0;
                     state_in = rmest_pkg::ST_PT_RD;
                  end
               end
            end
         end
         rmest_pkg::ST_PT_RD: begin
            ram_rd_addr = i_ff[IDX_W-1:0];
            state_in    = rmest_pkg::ST_PT_CAP;
         end
         rmest_pkg::ST_PT_CAP: begin
            // First point of task i is its own period.
            pi_in     = ram_rd_data[T-1:0];
            s_in      = ram_rd_data[T-1:0];
            j_in      = '0;
            demand_in = '0;
            state_in  = rmest_pkg::ST_J_RD;
         end
         rmest_pkg::ST_J_RD: begin
            ram_rd_addr = j_ff[IDX_W-1:0];
            state_in    = rmest_pkg::ST_J_CAP;
         end
         rmest_pkg::ST_J_CAP: begin
            c_in      = ram_rd_data[2*T-1:T];
            div_start = 1'b1;
            state_in  = rmest_pkg::ST_DIV;
         end
         rmest_pkg::ST_DIV: begin
            if (div_st.done) begin
               prod_in  = PROD_W'(c_ff) * PROD_W'(div_jobs);
               state_in = rmest_pkg::ST_ACC;
            end
         end
         rmest_pkg::ST_ACC: begin
            demand_in = demand_sum;
            if (demand_sum > DEM_W'(s_ff)) begin
               // Demand exceeds this point: next one, else next task or FAIL.
               if (s_next <= {1'b0, tmax_ff}) begin
                  s_in      = s_next[T-1:0];
                  j_in      = '0;
                  demand_in = '0;
                  state_in  = rmest_pkg::ST_J_RD;
               end else if (i_ff + CNT_W'(1) == count_ff) begin
                  finish     = 1'b1;
                  fin_status = rmest_pkg::STATUS_FAIL;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = rmest_pkg::ST_PT_RD;
               end
            end else if (j_ff + CNT_W'(1) == count_ff) begin
               // Every task fits by this point.
               finish     = 1'b1;
               fin_status = rmest_pkg::STATUS_OK;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = rmest_pkg::ST_J_RD;
            end
         end
         default: begin
            state_in = rmest_pkg::ST_LOAD;
         end
      endcase

      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_count_in  = (fin_status == rmest_pkg::STATUS_OK)
                         ? count_ext[rmest_pkg::COUNT_W-1:0] : '0;
         state_in      = rmest_pkg::ST_LOAD;
         count_in      = '0;
         tmax_in       = '0;
         over_in       = 1'b0;
         i_in          = '0;
         j_in          = '0;
         demand_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff         <= pi_in;
      s_ff          <= s_in;
      c_ff          <= c_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= rmest_pkg::ST_LOAD;
         count_ff     <= '0;
         tmax_ff      <= '0;
         over_ff      <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         demand_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tmax_ff      <= tmax_in;
         over_ff      <= over_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         demand_ff    <= demand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_status_ff};

   `RMEST_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(MAX_TASKS))
   `RMEST_ASSERT_IMPL(a_div_busy_state, div_st.busy, state_ff == rmest_pkg::ST_DIV)
   `RMEST_ASSERT_IMPL(a_acc_index, state_ff == rmest_pkg::ST_ACC, (i_ff < count_ff) && (j_ff < count_ff))
   `RMEST_ASSERT_IMPL(a_result_clears_set, $rose(rsp_valid_ff), (count_ff == '0) && !over_ff)

endmodule

// File: sv/rmest_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rmest_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rmest_div.sv
// Shared restoring divider that returns the ceiling of dividend over divisor.
module rmest_div #(
   parameter int W = rmest_pkg::TIME_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [W-1:0]             dividend,
   input  logic [W-1:0]             divisor,
   output logic [W-1:0]             jobs,
   output rmest_pkg::div_status_type status
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // One quotient bit per cycle, most significant first.
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // A nonzero remainder rounds the quotient up.
   assign jobs        = quo_ff + W'(rem_ff != '0);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
